// File: rtl/core/gde_pkg.sv
package gde_pkg;

  localparam int DefMaxWidth  = 1024;
  localparam int DefMaxHeight = 1024;

  localparam int CfgSizeW = 11;
  localparam int CfgIdxW  = 3;
  localparam int PixelW   = 24;
  localparam int GreyW    = 8;

  localparam logic [CfgSizeW-1:0] ResetFrameWidth  = 11'd640;
  localparam logic [CfgSizeW-1:0] ResetFrameHeight = 11'd480;
  localparam logic [GreyW-1:0]    ResetMaxValue    = 8'd255;

  // Fixed-point weights that sum to 256, with a half for rounding.
  localparam logic [7:0] GreyWeightR = 8'd51;
  localparam logic [7:0] GreyWeightG = 8'd179;
  localparam logic [7:0] GreyWeightB = 8'd26;
  localparam logic [7:0] GreyRound   = 8'd128;

  // The sum of two squares of 8-bit differences needs 17 bits.
  localparam int SqW   = 17;
  localparam int RootW = 18;

  localparam int QueueDepth = 2;

  typedef enum logic [CfgIdxW-1:0] {
    RegFrameWidth  = 3'd0,
    RegFrameHeight = 3'd1,
    RegEdgeMode    = 3'd2,
    RegColourInput = 3'd3,
    RegMaxValue    = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    EdgeHoriz = 2'd0,
    EdgeVert  = 2'd1,
    EdgeMag   = 2'd2
  } edge_mode_e;

  typedef enum logic [3:0] {
    BkIdle,
    BkWrite,
    BkReadLeft,
    BkReadRight,
    BkReadUp,
    BkReadDown,
    BkDiff,
    BkSquare,
    BkSum,
    BkRoot,
    BkOut
  } back_state_e;

endpackage

// File: rtl/core/gde_ram.sv
module gde_ram #(
  parameter int Width = 8,
  parameter int Depth = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/gde_queue.sv
module gde_queue #(
  parameter int DataWidth = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  logic [DataWidth-1:0] data_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output logic [DataWidth-1:0] data_o,
  output logic                 empty_o
);

  localparam int Depth = gde_pkg::QueueDepth;
  localparam int PtrW  = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);

  logic [DataWidth-1:0] slot_q [Depth];
  logic [PtrW-1:0]      wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]      count_q, count_d;
  logic                 do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = slot_q[rptr_q];

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wptr_q] <= data_i;
    end
  end

endmodule

// File: rtl/core/gde_front.sv
module gde_front #(
  parameter int MaxWidth  = gde_pkg::DefMaxWidth,
  parameter int MaxHeight = gde_pkg::DefMaxHeight,
  parameter int OpW       = 7 + 2 * $clog2(MaxWidth) + gde_pkg::GreyW
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         accept_i,
  input  logic                         cmd_i,
  input  logic [gde_pkg::PixelW-1:0]   pixel_value_i,
  input  logic [gde_pkg::CfgSizeW-1:0] frame_width_i,
  input  logic [gde_pkg::CfgSizeW-1:0] frame_height_i,
  input  logic                         colour_input_i,
  output logic                         op_valid_o,
  output logic [OpW-1:0]               op_o
);

  localparam int CW = $clog2(MaxWidth);
  localparam int WW = $clog2(MaxWidth + 1);
  localparam int RW = (MaxHeight > 1) ? $clog2(MaxHeight) : 1;
  localparam int HW = $clog2(MaxHeight + 1) + 1;

  typedef struct packed {
    logic                      res;
    logic                      wr;
    logic                      d_mem;
    logic                      last;
    logic                      p;
    logic                      q;
    logic                      wr_par;
    logic [CW-1:0]             c;
    logic [CW-1:0]             wm1;
    logic [gde_pkg::GreyW-1:0] g;
  } op_t;

  logic [CW-1:0] col_q, col_d, dcol_q, dcol_d, dwm1_q, dwm1_d;
  logic [RW-1:0] row_q, row_d;
  logic [WW-1:0] pending_q, pending_d;
  logic          dpar_q, dpar_d, dabove_q, dabove_d;

  logic [WW-1:0] w;
  logic [HW-1:0] h, r0;
  logic [CW-1:0] c;
  logic [RW-1:0] r;
  logic [16:0]   grey_sum;
  logic [gde_pkg::GreyW-1:0] grey;
  op_t           op;

  always_comb begin
    if (frame_width_i == '0) begin
      w = WW'(1);
    end else if (32'(frame_width_i) > 32'(MaxWidth)) begin
      w = WW'(MaxWidth);
    end else begin
      w = WW'(frame_width_i);
    end
    if (frame_height_i == '0) begin
      h = HW'(1);
    end else if (32'(frame_height_i) > 32'(MaxHeight)) begin
      h = HW'(MaxHeight);
    end else begin
      h = HW'(frame_height_i);
    end
  end

  always_comb begin
    grey_sum = 17'(pixel_value_i[23:16]) * 17'(gde_pkg::GreyWeightR)
             + 17'(pixel_value_i[15:8]) * 17'(gde_pkg::GreyWeightG)
             + 17'(pixel_value_i[7:0]) * 17'(gde_pkg::GreyWeightB)
             + 17'(gde_pkg::GreyRound);
    grey = colour_input_i ? grey_sum[15:8] : pixel_value_i[7:0];
  end

  // Position of this pixel after any wrap caused by a size that shrank mid-frame.
  always_comb begin
    c  = col_q;
    r0 = HW'(row_q);
    if (WW'(col_q) >= w) begin
      c  = '0;
      r0 = r0 + 1'b1;
    end
    if (r0 >= h) begin
      r0 = '0;
    end
    r = RW'(r0);
  end

  always_comb begin
    col_d      = col_q;
    row_d      = row_q;
    pending_d  = pending_q;
    dcol_d     = dcol_q;
    dwm1_d     = dwm1_q;
    dpar_d     = dpar_q;
    dabove_d   = dabove_q;
    op_valid_o = 1'b0;
    op         = '0;
    if (accept_i) begin
      if (cmd_i) begin
        if (pending_q != '0) begin
          op_valid_o = 1'b1;
          op.res     = 1'b1;
          op.d_mem   = 1'b1;
          op.last    = (pending_q == WW'(1));
          op.p       = dpar_q;
          op.q       = dabove_q ? ~dpar_q : dpar_q;
          op.c       = dcol_q;
          op.wm1     = dwm1_q;
          pending_d  = pending_q - 1'b1;
          dcol_d     = dcol_q + 1'b1;
        end
      end else begin
        op_valid_o = 1'b1;
        op.res     = (r != '0);
        op.wr      = 1'b1;
        op.p       = ~r[0];
        op.q       = (HW'(r) >= HW'(2)) ? r[0] : ~r[0];
        op.wr_par  = r[0];
        op.c       = c;
        op.wm1     = CW'(w - 1'b1);
        op.g       = grey;
        pending_d  = '0;
        if (WW'(c) + 1'b1 >= w) begin
          col_d = '0;
          if (HW'(r) + 1'b1 >= h) begin
            pending_d = w;
            dcol_d    = '0;
            dwm1_d    = CW'(w - 1'b1);
            dpar_d    = r[0];
            dabove_d  = (r != '0);
            row_d     = '0;
          end else begin
            row_d = r + 1'b1;
          end
        end else begin
          col_d = c + 1'b1;
          row_d = r;
        end
      end
    end
  end

  assign op_o = op;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_q     <= '0;
      pending_q <= '0;
      dcol_q    <= '0;
      dwm1_q    <= '0;
      dpar_q    <= 1'b0;
      dabove_q  <= 1'b0;
    end else begin
      col_q     <= col_d;
      row_q     <= row_d;
      pending_q <= pending_d;
      dcol_q    <= dcol_d;
      dwm1_q    <= dwm1_d;
      dpar_q    <= dpar_d;
      dabove_q  <= dabove_d;
    end
  end

endmodule

// File: rtl/core/gde_back.sv
module gde_back #(
  parameter int MaxWidth = gde_pkg::DefMaxWidth,
  parameter int OpW      = 7 + 2 * $clog2(MaxWidth) + gde_pkg::GreyW
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [OpW-1:0]            op_i,
  input  logic                      op_empty_i,
  output logic                      op_pop_o,
  input  logic [1:0]                edge_mode_i,
  input  logic [gde_pkg::GreyW-1:0] max_value_i,
  output logic                      empty_o,
  input  logic                      pop_i,
  output logic [gde_pkg::GreyW-1:0] edge_value_o,
  output logic                      frame_last_o
);

  localparam int CW = $clog2(MaxWidth);
  localparam int AW = CW + 1;
  localparam int SqW = gde_pkg::SqW;
  localparam int RootW = gde_pkg::RootW;

  typedef struct packed {
    logic                      res;
    logic                      wr;
    logic                      d_mem;
    logic                      last;
    logic                      p;
    logic                      q;
    logic                      wr_par;
    logic [CW-1:0]             c;
    logic [CW-1:0]             wm1;
    logic [gde_pkg::GreyW-1:0] g;
  } op_t;

  gde_pkg::back_state_e state_q, state_d;
  op_t  op_in, op_q;

  logic [7:0]  left_q, right_q, up_q, down, dx_q, dy_q;
  logic [15:0] sqx_q, sqy_q;
  logic [RootW-1:0] rem_q, root_q, bit_q, trial;
  logic [CW-1:0] left_col, right_col;
  logic [AW-1:0] raddr;
  logic [7:0]  rdata;
  logic        we, out_load;
  logic        out_valid_q;
  logic [7:0]  out_edge_q, edge_val;
  logic        out_last_q;
  logic [RootW-1:0] rounded;

  assign op_in     = op_t'(op_i);
  assign left_col  = (op_q.c != '0) ? op_q.c - 1'b1 : '0;
  assign right_col = (op_q.c < op_q.wm1) ? op_q.c + 1'b1 : op_q.wm1;
  assign down      = op_q.d_mem ? rdata : op_q.g;
  assign trial     = root_q + bit_q;

  gde_ram #(
    .Width(gde_pkg::GreyW),
    .Depth(2 ** AW)
  ) u_line_store (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i({op_q.wr_par, op_q.c}),
    .wdata_i(op_q.g),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_comb begin
    rounded = (rem_q > root_q) ? root_q + 1'b1 : root_q;
    case (edge_mode_i)
      gde_pkg::EdgeHoriz: edge_val = dx_q;
      gde_pkg::EdgeVert:  edge_val = dy_q;
      gde_pkg::EdgeMag: begin
        edge_val = (rounded > RootW'(max_value_i)) ? max_value_i : rounded[7:0];
      end
      default:            edge_val = '0;
    endcase
    if (edge_val > max_value_i) begin
      edge_val = max_value_i;
    end
  end

  always_comb begin
    state_d  = state_q;
    op_pop_o = 1'b0;
    raddr    = '0;
    we       = 1'b0;
    out_load = 1'b0;
    case (state_q)
      gde_pkg::BkIdle: begin
        if (!op_empty_i) begin
          op_pop_o = 1'b1;
          state_d  = op_in.res ? gde_pkg::BkReadLeft : gde_pkg::BkWrite;
        end
      end
      gde_pkg::BkWrite: begin
        we      = 1'b1;
        state_d = gde_pkg::BkIdle;
      end
      gde_pkg::BkReadLeft: begin
        raddr   = {op_q.p, left_col};
        state_d = gde_pkg::BkReadRight;
      end
      gde_pkg::BkReadRight: begin
        raddr   = {op_q.p, right_col};
        state_d = gde_pkg::BkReadUp;
      end
      gde_pkg::BkReadUp: begin
        raddr   = {op_q.q, op_q.c};
        state_d = gde_pkg::BkReadDown;
      end
      gde_pkg::BkReadDown: begin
        raddr   = {op_q.p, op_q.c};
        state_d = gde_pkg::BkDiff;
      end
      gde_pkg::BkDiff: begin
        // All reads of this item are issued, so its own pixel may now be stored.
        we      = op_q.wr;
        state_d = (edge_mode_i == gde_pkg::EdgeMag) ? gde_pkg::BkSquare : gde_pkg::BkOut;
      end
      gde_pkg::BkSquare: state_d = gde_pkg::BkSum;
      gde_pkg::BkSum:    state_d = gde_pkg::BkRoot;
      gde_pkg::BkRoot: begin
        if (bit_q[0]) begin
          state_d = gde_pkg::BkOut;
        end
      end
      gde_pkg::BkOut: begin
        if (!out_valid_q || pop_i) begin
          out_load = 1'b1;
          state_d  = gde_pkg::BkIdle;
        end
      end
      default: state_d = gde_pkg::BkIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gde_pkg::BkIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      gde_pkg::BkIdle: begin
        if (op_pop_o) begin
          op_q <= op_in;
        end
      end
      gde_pkg::BkReadRight: left_q  <= rdata;
      gde_pkg::BkReadUp:    right_q <= rdata;
      gde_pkg::BkReadDown:  up_q    <= rdata;
      gde_pkg::BkDiff: begin
        dx_q <= (right_q > left_q) ? right_q - left_q : left_q - right_q;
        dy_q <= (down > up_q) ? down - up_q : up_q - down;
      end
      gde_pkg::BkSquare: begin
        sqx_q <= 16'(dx_q) * 16'(dx_q);
        sqy_q <= 16'(dy_q) * 16'(dy_q);
      end
      gde_pkg::BkSum: begin
        rem_q  <= RootW'(SqW'(sqx_q) + SqW'(sqy_q));
        root_q <= '0;
        bit_q  <= RootW'(1) << (SqW - 1);
      end
      gde_pkg::BkRoot: begin
        // One result bit per cycle; the remainder is left in rem_q for rounding.
        if (rem_q >= trial) begin
          rem_q  <= rem_q - trial;
          root_q <= (root_q >> 1) + bit_q;
        end else begin
          root_q <= root_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (pop_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_edge_q <= edge_val;
      out_last_q <= op_q.last;
    end
  end

  assign empty_o      = !out_valid_q;
  assign edge_value_o = out_edge_q;
  assign frame_last_o = out_last_q;

`ifndef NO_ASSERTIONS
  a_root_bit_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == gde_pkg::BkRoot |-> $onehot(bit_q))
    else $error("square root step bit is not one-hot");

  a_result_saturated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> edge_val <= max_value_i)
    else $error("edge result exceeds the saturation limit");

  a_pop_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    op_pop_o |=> state_q != gde_pkg::BkIdle)
    else $error("item taken from the queue but back end stayed idle");

  a_load_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || pop_i))
    else $error("result register overwritten before it was taken");
`endif

endmodule

// File: rtl/core/gradient_edge_detector.sv
// Channel   Handshake                  Payload
// input     push / full                cmd_i, pixel_value_i
// result    pop / empty                edge_value_o, frame_last_o
// config    cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// The back end takes one item at a time: an item that only stores its pixel passes the
// idle and write states; one with a result passes four line store reads on a single read
// port and a difference state, and in magnitude mode also the squares, their sum and the
// nine-step square root, before its result is loaded in the output state.
// The front end takes up to two items ahead into its queue while the back end works.
// Reset clears counters and handshake state; the line store needs no clearing pass.
// A full result register stalls the back end, which in turn fills the queue.
module gradient_edge_detector #(
  parameter int MAX_WIDTH  = gde_pkg::DefMaxWidth,
  parameter int MAX_HEIGHT = gde_pkg::DefMaxHeight
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  logic                          cmd_i,
  input  logic [gde_pkg::PixelW-1:0]    pixel_value_i,
  input  logic                          pop,
  output logic                          empty,
  output logic [gde_pkg::GreyW-1:0]     edge_value_o,
  output logic                          frame_last_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [gde_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [gde_pkg::CfgSizeW-1:0]  cfg_data_i
);

  localparam int OpW = 7 + 2 * $clog2(MAX_WIDTH) + gde_pkg::GreyW;

  logic [gde_pkg::CfgSizeW-1:0] frame_width_q, frame_height_q;
  logic [1:0]                   edge_mode_q;
  logic                         colour_input_q;
  logic [gde_pkg::GreyW-1:0]    max_value_q;

  logic           accept, op_valid, op_pop, op_empty;
  logic [OpW-1:0] op_front, op_back;

  assign cfg_ready_o = 1'b1;
  assign accept      = push && !full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= gde_pkg::ResetFrameWidth;
      frame_height_q <= gde_pkg::ResetFrameHeight;
      edge_mode_q    <= gde_pkg::EdgeMag;
      colour_input_q <= 1'b0;
      max_value_q    <= gde_pkg::ResetMaxValue;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        gde_pkg::RegFrameWidth:  frame_width_q  <= cfg_data_i;
        gde_pkg::RegFrameHeight: frame_height_q <= cfg_data_i;
        gde_pkg::RegEdgeMode:    edge_mode_q    <= cfg_data_i[1:0];
        gde_pkg::RegColourInput: colour_input_q <= cfg_data_i[0];
        gde_pkg::RegMaxValue:    max_value_q    <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  gde_front #(
    .MaxWidth (MAX_WIDTH),
    .MaxHeight(MAX_HEIGHT),
    .OpW      (OpW)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .cmd_i         (cmd_i),
    .pixel_value_i (pixel_value_i),
    .frame_width_i (frame_width_q),
    .frame_height_i(frame_height_q),
    .colour_input_i(colour_input_q),
    .op_valid_o    (op_valid),
    .op_o          (op_front)
  );

  gde_queue #(
    .DataWidth(OpW)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (op_valid),
    .data_i (op_front),
    .full_o (full),
    .pop_i  (op_pop),
    .data_o (op_back),
    .empty_o(op_empty)
  );

  gde_back #(
    .MaxWidth(MAX_WIDTH),
    .OpW     (OpW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_i        (op_back),
    .op_empty_i  (op_empty),
    .op_pop_o    (op_pop),
    .edge_mode_i (edge_mode_q),
    .max_value_i (max_value_q),
    .empty_o     (empty),
    .pop_i       (pop),
    .edge_value_o(edge_value_o),
    .frame_last_o(frame_last_o)
  );

endmodule
